FILE: hw/rtl/lebdec_pkg.sv
// Shared types, codes and helper functions for the typed LEB128 decoder.
package lebdec_pkg;

	// Value kinds, latched on the first byte of a value
	typedef enum logic [2:0] {
		KIND_U1  = 3'd0,
		KIND_U7  = 3'd1,
		KIND_U32 = 3'd2,
		KIND_S7  = 3'd3,
		KIND_S32 = 3'd4,
		KIND_S64 = 3'd5
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_LONG  = 2'd1,
		ST_TRUNCATED = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned COUNT_W = 4;

	// Index of the last byte a value may have
	localparam logic [COUNT_W-1:0] SEEN_MAX = 4'd9;

	// Tenth byte of a signed 64-bit value: bits above the sign bit
	localparam logic [7:0] TAIL_MASK = 8'hfe;
	localparam logic [7:0] TAIL_NEG  = 8'h7e;

	// Decoder state carried from one byte to the next
	typedef struct packed {
		logic [VALUE_W-1:0] acc;
		logic [COUNT_W-1:0] seen;
		kind_t              kind;
		logic               busy;
	} state_t;

	// One finished value
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [COUNT_W-1:0] count;
		status_t            status;
	} result_t;

	// Map a raw kind code onto a kind; codes without meaning decode as signed 64-bit
	function automatic kind_t to_kind(input logic [2:0] raw);
		kind_t k;
		if (raw > 3'(KIND_S64)) begin
			k = KIND_S64;
		end else begin
			k = kind_t'(raw);
		end
		return k;
	endfunction

	// Index of the last allowed byte for each kind (limit minus one)
	function automatic logic [COUNT_W-1:0] last_idx(input kind_t k);
		logic [COUNT_W-1:0] idx;
		case (k)
			KIND_U32: idx = 4'd4;
			KIND_S32: idx = 4'd4;
			KIND_S64: idx = 4'd9;
			default:  idx = 4'd0;
		endcase
		return idx;
	endfunction

	// Seven times a byte index, as a bit position
	function automatic logic [6:0] mul7(input logic [COUNT_W-1:0] n);
		logic [6:0] wide;
		wide = {3'd0, n};
		return (wide << 3) - wide;
	endfunction

endpackage

FILE: hw/rtl/leb128_typed_decoder.sv
// Top level of the typed LEB128 decoder: input stage, decode step, result stage.
//
//  channel  | direction | handshake                   | fields
//  byte     | in        | byte_valid / byte_stall     | data_byte, kind, buffer_last
//  result   | out       | result_valid / result_stall | value, byte_count, status
//
// One byte per cycle while byte_stall is low: a byte is registered in the input stage,
// and the decode step merges it into the state and loads a finished value at the same edge.
// Throughput is set by the single accumulator update per byte.
// Reset clears the stage valids and the decoder state (waiting for a first byte).
// While a result waits under result_stall, bytes that finish no value still pass;
// a byte that would finish another value holds the input stage and raises byte_stall.
module leb128_typed_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         data_byte,
	input  logic [2:0]         kind,
	input  logic               buffer_last,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [63:0] value,
	output logic [3:0]         byte_count,
	output logic [1:0]         status
);

	logic                byte_valid_s1;
	logic [7:0]          data_byte_s1;
	logic [2:0]          kind_s1;
	logic                last_s1;
	lebdec_pkg::state_t  state_q;
	lebdec_pkg::state_t  state_nxt;
	lebdec_pkg::result_t res;
	lebdec_pkg::result_t result_s2;
	logic                result_valid_s2;
	logic                emit;
	logic                out_free;
	logic                s1_go;

	lebdec_step u_step (
		.cur         (state_q),
		.data_byte   (data_byte_s1),
		.kind        (kind_s1),
		.buffer_last (last_s1),
		.nxt         (state_nxt),
		.emit        (emit),
		.res         (res)
	);

	// advance the input stage unless its result has nowhere to go
	assign out_free   = !result_valid_s2 || !result_stall;
	assign s1_go      = byte_valid_s1 && (!emit || out_free);
	assign byte_stall = byte_valid_s1 && !s1_go;

	// input stage: hold the beat until the decode step takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			byte_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			data_byte_s1 <= data_byte;
			kind_s1      <= kind;
			last_s1      <= buffer_last;
		end
	end

	// decoder state: advance once per consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.acc  <= '0;
			state_q.seen <= '0;
			state_q.kind <= lebdec_pkg::KIND_U1;
			state_q.busy <= 1'b0;
		end else if (s1_go) begin
			state_q <= state_nxt;
		end
	end

	// result stage: load a finished value, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_s2 <= 1'b0;
		end else if (s1_go && emit) begin
			result_valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			result_s2 <= res;
		end
	end

	assign result_valid = result_valid_s2;
	assign value        = $signed(result_s2.value);
	assign byte_count   = result_s2.count;
	assign status       = result_s2.status;

	// a finished value leaves the decoder waiting for a first byte
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && emit |=> !state_q.busy)
		else $error("state still busy after a finished value");

	// error results carry a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_s2 && result_s2.status != lebdec_pkg::ST_OK |-> result_s2.value == '0)
		else $error("error result with nonzero value");

	// byte count stays within one to ten
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_s2 |-> result_s2.count >= 4'd1 && result_s2.count <= 4'd10)
		else $error("byte count out of range");

	// input stalls only behind a waiting result
	assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> byte_valid_s1 && result_valid_s2 && emit)
		else $error("input stalled without a waiting result");

	// an open value never holds more than nine bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.seen <= lebdec_pkg::SEEN_MAX)
		else $error("byte index past the longest encoding");

endmodule

FILE: hw/rtl/lebdec_step.sv
// Per-byte decode step: merges one byte into the state and forms the result.
module lebdec_step (
	input  lebdec_pkg::state_t  cur,
	input  logic [7:0]          data_byte,
	input  logic [2:0]          kind,
	input  logic                buffer_last,
	output lebdec_pkg::state_t  nxt,
	output logic                emit,
	output lebdec_pkg::result_t res
);

	always_comb begin
		lebdec_pkg::kind_t k;
		logic [lebdec_pkg::COUNT_W-1:0] seen;
		logic [lebdec_pkg::COUNT_W-1:0] seen_n;
		logic [lebdec_pkg::VALUE_W-1:0] acc;
		logic [lebdec_pkg::VALUE_W-1:0] fill;
		logic [6:0] sh_in;
		logic [6:0] sh_top;
		logic [7:0] tail;

		// start a new value on the first byte, else resume
		if (!cur.busy) begin
			k    = lebdec_pkg::to_kind(kind);
			acc  = '0;
			seen = '0;
		end else begin
			k    = cur.kind;
			acc  = cur.acc;
			seen = (cur.seen > lebdec_pkg::SEEN_MAX) ? lebdec_pkg::SEEN_MAX : cur.seen;
		end

		// merge the seven payload bits at their position
		sh_in  = lebdec_pkg::mul7(seen);
		acc    = acc | ({57'd0, data_byte[6:0]} << sh_in[5:0]);
		seen_n = seen + 4'd1;
		sh_top = lebdec_pkg::mul7(seen_n);
		fill   = ~64'd0 << sh_top;
		tail   = data_byte & lebdec_pkg::TAIL_MASK;

		// defaults: keep going
		nxt.acc    = acc;
		nxt.seen   = seen_n;
		nxt.kind   = k;
		nxt.busy   = 1'b1;
		emit       = 1'b0;
		res.value  = '0;
		res.count  = seen_n;
		res.status = lebdec_pkg::ST_OK;

		if (data_byte[7]) begin
			// continuation byte: end only on length or buffer end
			if (seen >= lebdec_pkg::last_idx(k)) begin
				emit       = 1'b1;
				res.status = lebdec_pkg::ST_TOO_LONG;
			end else if (buffer_last) begin
				emit       = 1'b1;
				res.status = lebdec_pkg::ST_TRUNCATED;
			end
		end else begin
			// closing byte: range check and sign extension
			emit      = 1'b1;
			res.value = acc;
			unique case (k)
				lebdec_pkg::KIND_U1: begin
					if (acc[63:1] != '0) begin
						res.status = lebdec_pkg::ST_RANGE;
					end
				end
				lebdec_pkg::KIND_U7: begin
					res.value = acc;
				end
				lebdec_pkg::KIND_U32: begin
					if (acc[63:32] != '0) begin
						res.status = lebdec_pkg::ST_RANGE;
					end
				end
				lebdec_pkg::KIND_S7: begin
					if (data_byte[6]) begin
						res.value = acc | (~64'd0 << 7);
					end
				end
				lebdec_pkg::KIND_S32: begin
					if (acc[63:31] == '0) begin
						if (data_byte[6]) begin
							res.value = acc | fill;
						end
					end else if (acc[63:31] == 33'hf) begin
						res.value = acc | fill;
					end else begin
						res.status = lebdec_pkg::ST_RANGE;
					end
				end
				default: begin
					if (sh_top < 7'd64) begin
						if (data_byte[6]) begin
							res.value = acc | fill;
						end
					end else if ((data_byte[0] && tail != lebdec_pkg::TAIL_NEG) ||
							(!data_byte[0] && tail != 8'd0)) begin
						res.status = lebdec_pkg::ST_RANGE;
					end
				end
			endcase
			if (res.status != lebdec_pkg::ST_OK) begin
				res.value = '0;
			end
		end

		// a finished value clears the state
		if (emit) begin
			nxt.acc  = '0;
			nxt.seen = '0;
			nxt.busy = 1'b0;
		end
	end

endmodule
